>>> rtl/ray_box_exit_point_macros.svh
// Assertion macros shared by the ray/box exit point RTL.
// Needs a clk and rst signal in scope where the macros are used.
`ifndef RAY_BOX_EXIT_POINT_MACROS_SVH
`define RAY_BOX_EXIT_POINT_MACROS_SVH
`ifndef SYNTHESIS
`define RBEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RBEP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBEP_ASSERT(lbl, prop, msg)
`define RBEP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/rbep_pkg.sv
// Types and constants for the ray/box exit point block.
// No dependencies.
`timescale 1ns / 1ps
package rbep_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUO_BITS      = 31;
  localparam int DIV_LAT       = QUO_BITS + 1;

  typedef enum logic [2:0] {
    FACE_LOW_X  = 3'd0,
    FACE_LOW_Y  = 3'd1,
    FACE_LOW_Z  = 3'd2,
    FACE_HIGH_X = 3'd3,
    FACE_HIGH_Y = 3'd4,
    FACE_HIGH_Z = 3'd5,
    FACE_NONE   = 3'd6
  } face_t;

  typedef struct packed {
    logic signed [31:0] ray_start_x;
    logic signed [31:0] ray_start_y;
    logic signed [31:0] ray_start_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic signed [31:0] box_low_x;
    logic signed [31:0] box_low_y;
    logic signed [31:0] box_low_z;
    logic signed [31:0] box_high_x;
    logic signed [31:0] box_high_y;
    logic signed [31:0] box_high_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] exit_x;
    logic signed [31:0] exit_y;
    logic signed [31:0] exit_z;
    logic [2:0]         exit_face;
  } res_t;

endpackage

>>> rtl/rbep_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, saturated to 31 bits.
// One quotient bit per stage; depends on rbep_pkg.
`timescale 1ns / 1ps
module rbep_div #(
  parameter int FRAC_BITS = rbep_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [32:0]                    num,
  input  logic [31:0]                    den,
  output logic [rbep_pkg::QUO_BITS-1:0]  quo
);
  localparam int QB = rbep_pkg::QUO_BITS;
  localparam int NW = 33 + FRAC_BITS;
  localparam int HW = NW - QB;

  logic [NW-1:0] n_full;
  logic [HW-1:0] n_hi;
  logic          ovf;

  logic [31:0]   rem  [0:QB];
  logic [31:0]   dv   [0:QB];
  logic [QB-1:0] nlo  [0:QB];
  logic [QB-1:0] qacc [0:QB];
  logic          sat  [0:QB];

  assign n_full = {num, {FRAC_BITS{1'b0}}};
  assign n_hi   = n_full[NW-1:QB];
  // quotient needs more than QB bits when the top part already reaches den
  assign ovf    = (32'(n_hi) >= den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= ovf ? 32'd0 : 32'(n_hi);
      dv[0]   <= den;
      nlo[0]  <= n_full[QB-1:0];
      qacc[0] <= '0;
      sat[0]  <= ovf;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem[k-1], nlo[k-1][QB-1]};
    assign ge    = (trial >= {1'b0, dv[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? 32'(trial - {1'b0, dv[k-1]}) : trial[31:0];
        dv[k]   <= dv[k-1];
        nlo[k]  <= {nlo[k-1][QB-2:0], 1'b0};
        qacc[k] <= {qacc[k-1][QB-2:0], ge};
        sat[k]  <= sat[k-1];
      end
    end
  end

  assign quo = sat[QB] ? {QB{1'b1}} : qacc[QB];

endmodule

>>> rtl/ray_box_exit_point.sv
// Ray / axis-aligned box exit point. Takes one request per cycle while no result
// waits under stall. A request passes through the input stage, the setup stage,
// the 32-stage distance divider (an operand stage plus one stage per quotient
// bit), two minimum select stages, the multiply stage and the output stage. The
// whole pipeline holds while a result waits under stall.
// Depends on rbep_pkg, rbep_div and the macro header.
`timescale 1ns / 1ps
`include "ray_box_exit_point_macros.svh"
module ray_box_exit_point #(
  parameter int FRAC_BITS = rbep_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rbep_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_stall,
  output rbep_pkg::res_t res_data
);
  localparam int QB = rbep_pkg::QUO_BITS;
  localparam int DL = rbep_pkg::DIV_LAT;

  typedef struct packed {
    rbep_pkg::req_t p;
    logic [2:0]     qual;
    logic [2:0]     hib;
  } side_t;

  logic adv;
  assign adv       = !res_valid || !res_stall;
  assign req_stall = !adv;

  // stage A: input register
  logic           v_a;
  rbep_pkg::req_t p_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (adv) begin
      v_a <= req_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) p_a <= req_data;
  end

  // stage B: face qualify, numerator and divisor magnitude
  logic signed [31:0] s [3];
  logic signed [31:0] d [3];
  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  logic [2:0]  hq, lq;
  logic [32:0] num_c [3];
  logic [31:0] den_c [3];

  always_comb begin
    s[0] = p_a.ray_start_x;  s[1] = p_a.ray_start_y;  s[2] = p_a.ray_start_z;
    d[0] = p_a.ray_dir_x;    d[1] = p_a.ray_dir_y;    d[2] = p_a.ray_dir_z;
    lo[0] = p_a.box_low_x;   lo[1] = p_a.box_low_y;   lo[2] = p_a.box_low_z;
    hi[0] = p_a.box_high_x;  hi[1] = p_a.box_high_y;  hi[2] = p_a.box_high_z;
    for (int i = 0; i < 3; i++) begin
      hq[i] = (hi[i] >= s[i]) && (d[i] > 32'sd0);
      lq[i] = !hq[i] && (lo[i] <= s[i]) && (d[i] < 32'sd0);
      num_c[i] = hq[i] ? 33'({hi[i][31], hi[i]} - {s[i][31], s[i]})
                       : 33'({s[i][31], s[i]} - {lo[i][31], lo[i]});
      den_c[i] = hq[i] ? d[i] : 32'(33'd0 - {d[i][31], d[i]});
    end
  end

  logic        v_b;
  side_t       sb_b;
  logic [32:0] num_b [3];
  logic [31:0] den_b [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (adv) begin
      v_b <= v_a;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_b.p    <= p_a;
      sb_b.qual <= hq | lq;
      sb_b.hib  <= hq;
      for (int i = 0; i < 3; i++) begin
        num_b[i] <= num_c[i];
        den_b[i] <= den_c[i];
      end
    end
  end

  // dividers, with the side data delayed alongside
  logic [QB-1:0] t_q [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    rbep_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (adv),
      .num (num_b[i]),
      .den (den_b[i]),
      .quo (t_q[i])
    );
  end

  logic [DL-1:0] v_line;
  side_t         sb_line [0:DL-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      v_line <= '0;
    end else if (adv) begin
      v_line <= {v_line[DL-2:0], v_b};
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_line[0] <= sb_b;
      for (int k = 1; k < DL; k++) sb_line[k] <= sb_line[k-1];
    end
  end

  // stage C: pick the smaller of x and y
  side_t         sb_l;
  logic          use_y;
  assign sb_l  = sb_line[DL-1];
  assign use_y = sb_l.qual[1] && (!sb_l.qual[0] || (t_q[1] < t_q[0]));

  logic          v_c, f_c;
  side_t         sb_c;
  logic [QB-1:0] t_c, tz_c;
  logic [1:0]    ax_c;
  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (adv) begin
      v_c <= v_line[DL-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_c <= sb_l;
      f_c  <= sb_l.qual[0] || sb_l.qual[1];
      t_c  <= use_y ? t_q[1] : t_q[0];
      ax_c <= use_y ? 2'd1 : 2'd0;
      tz_c <= t_q[2];
    end
  end

  // stage D: fold in z, form the face code
  logic          use_z;
  logic [1:0]    ax_w;
  logic          hib_w;
  assign use_z = sb_c.qual[2] && (!f_c || (tz_c < t_c));
  assign ax_w  = use_z ? 2'd2 : ax_c;
  assign hib_w = sb_c.hib[ax_w];

  logic                 v_d, f_d;
  side_t                sb_d;
  logic [QB-1:0]        t_d;
  logic [1:0]           ax_d;
  rbep_pkg::face_t      face_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
    end else if (adv) begin
      v_d <= v_c;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_d <= sb_c;
      f_d  <= f_c || sb_c.qual[2];
      t_d  <= use_z ? tz_c : t_c;
      ax_d <= ax_w;
      if (!(f_c || sb_c.qual[2])) begin
        face_d <= rbep_pkg::FACE_NONE;
      end else begin
        face_d <= rbep_pkg::face_t'(3'(ax_w) + (hib_w ? 3'd3 : 3'd0));
      end
    end
  end

  // stage E: dir * t on every axis
  logic signed [31:0] dd [3];
  always_comb begin
    dd[0] = sb_d.p.ray_dir_x;
    dd[1] = sb_d.p.ray_dir_y;
    dd[2] = sb_d.p.ray_dir_z;
  end

  logic                 v_e, f_e;
  side_t                sb_e;
  logic [1:0]           ax_e;
  rbep_pkg::face_t      face_e;
  logic signed [63:0]   prod [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
    end else if (adv) begin
      v_e <= v_d;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_e   <= sb_d;
      f_e    <= f_d;
      ax_e   <= ax_d;
      face_e <= face_d;
      for (int i = 0; i < 3; i++) begin
        prod[i] <= 64'(dd[i] * $signed({1'b0, t_d}));
      end
    end
  end

  // stage F: floor shift, add start, saturate, select bound
  logic signed [31:0] se [3];
  logic signed [31:0] be [3];
  logic signed [63:0] step [3];
  logic signed [64:0] sum [3];
  logic signed [31:0] pt [3];
  always_comb begin
    se[0] = sb_e.p.ray_start_x;  se[1] = sb_e.p.ray_start_y;  se[2] = sb_e.p.ray_start_z;
    be[0] = sb_e.hib[0] ? sb_e.p.box_high_x : sb_e.p.box_low_x;
    be[1] = sb_e.hib[1] ? sb_e.p.box_high_y : sb_e.p.box_low_y;
    be[2] = sb_e.hib[2] ? sb_e.p.box_high_z : sb_e.p.box_low_z;
    for (int i = 0; i < 3; i++) begin
      step[i] = prod[i] >>> FRAC_BITS;
      sum[i]  = 65'(se[i]) + 65'(step[i]);
      if (!f_e) begin
        pt[i] = '0;
      end else if (ax_e == 2'(i)) begin
        pt[i] = be[i];
      end else if (sum[i][64:31] == {34{1'b0}} || sum[i][64:31] == {34{1'b1}}) begin
        pt[i] = sum[i][31:0];
      end else begin
        pt[i] = sum[i][64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v_e;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      res_data.exit_x    <= pt[0];
      res_data.exit_y    <= pt[1];
      res_data.exit_z    <= pt[2];
      res_data.exit_face <= face_e;
    end
  end

  `RBEP_ASSERT(a_none_zero, res_valid && res_data.exit_face == rbep_pkg::FACE_NONE |-> res_data.exit_x == 32'sd0 && res_data.exit_y == 32'sd0 && res_data.exit_z == 32'sd0, "no-face result with nonzero point")
  `RBEP_ASSERT(a_face_axis, v_d && f_d |-> face_d != rbep_pkg::FACE_NONE && (3'(ax_d) == face_d || 3'(ax_d) + 3'd3 == face_d), "face code disagrees with winning axis")
  `RBEP_ASSERT(a_stall_src, req_stall |-> res_valid && res_stall, "request held without a waiting result")

endmodule
